>>> hw/rtl/bsfr_pkg.sv
// Shared types, constants and the CRC-16 byte step for the byte-stuffed frame receiver.
// No dependencies; every other file of the block imports this package.
package bsfr_pkg;

    // Framing and escape bytes on the line.
    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_FLAG  = 8'h5E;
    localparam logic [7:0] ESC_ESC   = 8'h5D;

    // The unescaped byte count saturates here; only compares against 8-bit limits follow it.
    localparam logic [7:0] COUNT_SAT     = 8'hFF;
    localparam logic [7:0] MIN_LEN_RESET = 8'd6;

    // End-of-frame status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_CRC   = 2'd1;
    localparam logic [1:0] ST_SHORT = 2'd2;
    localparam logic [1:0] ST_LONG  = 2'd3;

    // Number of commands the queue between the front and the back can hold.
    localparam int QUEUE_DEPTH = 4;

    // One classified line byte: zero to two unescaped bytes to push, then maybe a frame end.
    typedef struct packed {
        logic [1:0] push_cnt;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic       is_end;
        logic       too_long;
    } t_cmd;

    // Queue fill status as seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // One byte of CRC-16 with polynomial 0x1021, MSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0]  x;
        logic [15:0] xw;
        x  = crc[15:8] ^ b;
        x  = x ^ (x >> 4);
        xw = {8'h00, x};
        return {crc[7:0], 8'h00} ^ (xw << 12) ^ (xw << 5) ^ xw;
    endfunction

endpackage

>>> hw/rtl/byte_stuffed_frame_receiver.sv
// Byte-stuffed frame receiver: flag framing, escape removal and CRC-16 check.
// Instantiates bsfr_front, bsfr_queue and bsfr_back; depends on bsfr_pkg.
//
// The receiver takes one raw line byte per clock cycle. The front part removes
// the escaping and tracks overlong frames in the same cycle and queues a command
// for each byte that leads to work; the back part then handles each unescaped
// byte and each frame end in turn, so a byte that yields two results (a broken
// escape followed by an ordinary byte, or a pending escape before the closing
// flag) keeps the back part busy for both results. A four-entry command queue
// absorbs these bursts and output stalls; input stall rises only when it is full.
// Each frame gives its payload bytes (all but the last two unescaped bytes) and
// then one end transaction with status ok, CRC error, too short or too long.
// After reset the receiver hunts for a flag; no clearing pass is needed.
module byte_stuffed_frame_receiver #(
    parameter int MAX_RAW_BYTES = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_payload_byte,
    output logic       o_frame_end,
    output logic [1:0] o_frame_status,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data
);
    import bsfr_pkg::*;

    logic    q_push;
    logic    q_pop;
    t_cmd    front_cmd;
    t_cmd    head_cmd;
    t_q_stat q_stat;

    // Front part: accept and classify line bytes.
    bsfr_front #(
        .MAX_RAW_BYTES (MAX_RAW_BYTES)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_rx_byte (i_rx_byte),
        .o_push    (q_push),
        .o_cmd     (front_cmd),
        .i_q_stat  (q_stat)
    );

    // Command queue between the two parts.
    bsfr_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_cmd    (front_cmd),
        .i_pop    (q_pop),
        .o_cmd    (head_cmd),
        .o_q_stat (q_stat)
    );

    // Back part: payload streaming, CRC and frame verdict.
    bsfr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (head_cmd),
        .i_q_stat       (q_stat),
        .o_pop          (q_pop),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_payload_byte (o_payload_byte),
        .o_frame_end    (o_frame_end),
        .o_frame_status (o_frame_status)
    );

    // The back part never takes a command from an empty queue.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) q_pop |-> !q_stat.empty)
        else $error("command taken from empty queue");

    // Reset leaves no result pending.
    assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Payload transactions carry no status.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_frame_end) |-> (o_frame_status == ST_OK))
        else $error("payload transaction with nonzero status");

    // End transactions carry a zero payload byte.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_end) |-> (o_payload_byte == 8'h00))
        else $error("end transaction with nonzero payload");

endmodule

>>> hw/rtl/bsfr_front.sv
// Front part of the frame receiver: accepts line bytes, undoes the escaping and
// tracks overlong frames, then queues one command per byte that leads to work. Depends on bsfr_pkg.
module bsfr_front #(
    parameter int MAX_RAW_BYTES = 128
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [7:0]      i_rx_byte,
    output logic            o_push,
    output bsfr_pkg::t_cmd  o_cmd,
    input  bsfr_pkg::t_q_stat i_q_stat
);
    import bsfr_pkg::*;

    localparam int RAW_W = $clog2(MAX_RAW_BYTES + 1);

    logic             r_esc_pending, n_esc_pending;
    logic             r_dropping, n_dropping;
    logic [RAW_W-1:0] r_raw_count, n_raw_count;
    logic             accept;
    t_cmd             cmd;

    // A transaction is taken whenever the queue has room.
    assign o_stall = i_q_stat.full;
    assign accept  = i_valid && !i_q_stat.full;

    // Classify the byte and work out the next escape and overlong state.
    always_comb begin
        n_esc_pending = r_esc_pending;
        n_dropping    = r_dropping;
        n_raw_count   = r_raw_count;
        cmd           = '0;
        if (i_rx_byte == FLAG_BYTE) begin
            // A pending escape counts as a literal escape byte before the frame is judged.
            if (!r_dropping && r_esc_pending) begin
                cmd.push_cnt = 2'd1;
                cmd.byte0    = ESC_BYTE;
            end
            cmd.is_end    = 1'b1;
            cmd.too_long  = r_dropping;
            n_esc_pending = 1'b0;
            n_dropping    = 1'b0;
            n_raw_count   = '0;
        end else if (r_dropping) begin
            n_dropping = 1'b1;
        end else if (r_raw_count >= RAW_W'(MAX_RAW_BYTES)) begin
            n_dropping    = 1'b1;
            n_esc_pending = 1'b0;
        end else begin
            n_raw_count = r_raw_count + RAW_W'(1);
            if (r_esc_pending) begin
                n_esc_pending = 1'b0;
                if (i_rx_byte == ESC_FLAG) begin
                    cmd.push_cnt = 2'd1;
                    cmd.byte0    = FLAG_BYTE;
                end else if (i_rx_byte == ESC_ESC) begin
                    cmd.push_cnt = 2'd1;
                    cmd.byte0    = ESC_BYTE;
                end else begin
                    // Unknown escape: keep the escape byte and treat this byte as fresh.
                    cmd.byte0 = ESC_BYTE;
                    if (i_rx_byte == ESC_BYTE) begin
                        cmd.push_cnt  = 2'd1;
                        n_esc_pending = 1'b1;
                    end else begin
                        cmd.push_cnt = 2'd2;
                        cmd.byte1    = i_rx_byte;
                    end
                end
            end else if (i_rx_byte == ESC_BYTE) begin
                n_esc_pending = 1'b1;
            end else begin
                cmd.push_cnt = 2'd1;
                cmd.byte0    = i_rx_byte;
            end
        end
    end

    // Only bytes that lead to some work are queued.
    assign o_push = accept && ((cmd.push_cnt != 2'd0) || cmd.is_end);
    assign o_cmd  = cmd;

    // Escape and overlong state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc_pending <= 1'b0;
            r_dropping    <= 1'b0;
            r_raw_count   <= '0;
        end else if (accept) begin
            r_esc_pending <= n_esc_pending;
            r_dropping    <= n_dropping;
            r_raw_count   <= n_raw_count;
        end
    end

endmodule

>>> hw/rtl/bsfr_queue.sv
// Short command queue between the front and the back of the frame receiver.
// Depends on bsfr_pkg for the command type and the depth.
module bsfr_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  bsfr_pkg::t_cmd    i_cmd,
    input  logic              i_pop,
    output bsfr_pkg::t_cmd    o_cmd,
    output bsfr_pkg::t_q_stat o_q_stat
);
    import bsfr_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_q_stat.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_q_stat.empty = (r_count == '0);
    assign do_push        = i_push && !o_q_stat.full;
    assign do_pop         = i_pop && !o_q_stat.empty;
    assign o_cmd          = r_mem[r_rd_ptr];

    // Storage for queued commands.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

>>> hw/rtl/bsfr_back.sv
// Back part of the frame receiver: holds back the CRC bytes, streams payload,
// runs the CRC and judges each frame. Depends on bsfr_pkg.
module bsfr_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bsfr_pkg::t_cmd    i_cmd,
    input  bsfr_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    input  logic              i_cfg_wr_en,
    input  logic [7:0]        i_cfg_wr_data,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_payload_byte,
    output logic              o_frame_end,
    output logic [1:0]        o_frame_status
);
    import bsfr_pkg::*;

    logic [7:0]  r_min_frame_length;
    logic        r_in_frame, n_in_frame;
    logic [7:0]  r_unesc_cnt, n_unesc_cnt;
    logic [7:0]  r_held0, n_held0;
    logic [7:0]  r_held1, n_held1;
    logic [15:0] r_crc, n_crc;
    logic        r_sub, n_sub;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_end;
    logic [1:0]  r_out_status;

    logic        out_free;
    logic        go;
    logic [1:0]  total_ops;
    logic        last_op;
    logic        cur_is_push;
    logic [7:0]  cur_byte;
    logic [1:0]  status;
    logic        emit;
    logic [7:0]  emit_byte;
    logic        emit_end;
    logic [1:0]  emit_status;

    // Output register is free when empty or being taken this cycle.
    assign out_free    = !r_out_valid || !i_stall;
    assign total_ops   = i_cmd.push_cnt + {1'b0, i_cmd.is_end};
    assign last_op     = (({1'b0, r_sub} + 2'd1) == total_ops);
    assign cur_is_push = ({1'b0, r_sub} < i_cmd.push_cnt);
    assign cur_byte    = r_sub ? i_cmd.byte1 : i_cmd.byte0;

    // While hunting no result can come out, so the output register need not be free.
    assign go    = !i_q_stat.empty && (!r_in_frame || out_free);
    assign o_pop = go && last_op;

    // Frame verdict from the overlong flag, held bytes, count and running CRC.
    always_comb begin
        if (i_cmd.too_long) begin
            status = ST_LONG;
        end else if ((r_unesc_cnt < 8'd2) || (r_unesc_cnt < r_min_frame_length)) begin
            status = ST_SHORT;
        end else if ((r_held0 == r_crc[7:0]) && (r_held1 == r_crc[15:8])) begin
            status = ST_OK;
        end else begin
            status = ST_CRC;
        end
    end

    // Carry out one push or one frame end per cycle while not stalled.
    always_comb begin
        n_in_frame  = r_in_frame;
        n_unesc_cnt = r_unesc_cnt;
        n_held0     = r_held0;
        n_held1     = r_held1;
        n_crc       = r_crc;
        n_sub       = r_sub;
        emit        = 1'b0;
        emit_byte   = 8'h00;
        emit_end    = 1'b0;
        emit_status = ST_OK;
        if (go) begin
            n_sub = last_op ? 1'b0 : ~r_sub;
            if (!r_in_frame) begin
                // Hunting: pushes are ignored and a flag opens a fresh frame.
                if (!cur_is_push) begin
                    n_in_frame  = 1'b1;
                    n_unesc_cnt = '0;
                    n_held0     = '0;
                    n_held1     = '0;
                    n_crc       = '0;
                end
            end else if (cur_is_push) begin
                if (r_unesc_cnt >= 8'd2) begin
                    emit      = 1'b1;
                    emit_byte = r_held0;
                    n_crc     = crc_byte(r_crc, r_held0);
                    n_held0   = r_held1;
                    n_held1   = cur_byte;
                end else if (r_unesc_cnt[0]) begin
                    n_held1 = cur_byte;
                end else begin
                    n_held0 = cur_byte;
                end
                if (r_unesc_cnt != COUNT_SAT) begin
                    n_unesc_cnt = r_unesc_cnt + 8'd1;
                end
            end else begin
                // Closing flag: report, clear, and hunt again only after a good frame.
                emit        = 1'b1;
                emit_end    = 1'b1;
                emit_status = status;
                n_in_frame  = (status != ST_OK);
                n_unesc_cnt = '0;
                n_held0     = '0;
                n_held1     = '0;
                n_crc       = '0;
            end
        end
    end

    // Frame state, configuration and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_frame_length <= MIN_LEN_RESET;
            r_in_frame         <= 1'b0;
            r_unesc_cnt        <= '0;
            r_sub              <= 1'b0;
            r_out_valid        <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_min_frame_length <= i_cfg_wr_data;
            end
            r_in_frame  <= n_in_frame;
            r_unesc_cnt <= n_unesc_cnt;
            r_sub       <= n_sub;
            if (out_free) begin
                r_out_valid <= emit;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_held0 <= n_held0;
        r_held1 <= n_held1;
        r_crc   <= n_crc;
        if (out_free) begin
            r_out_byte   <= emit_byte;
            r_out_end    <= emit_end;
            r_out_status <= emit_status;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_payload_byte = r_out_byte;
    assign o_frame_end    = r_out_end;
    assign o_frame_status = r_out_status;

endmodule
